// ===== hdl/strict_ipv4_dotted_quad_parser_unit_defines.svh =====
// Assertion macros for the strict IPv4 dotted-quad parser.
// Used by the top level only; depends on a clock named clock and a reset named reset.
`ifndef STRICT_IPV4_DOTTED_QUAD_PARSER_UNIT_DEFINES_SVH
`define STRICT_IPV4_DOTTED_QUAD_PARSER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPV4P_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPV4P_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ipv4p_pkg.sv =====
// Shared types and character constants for the strict IPv4 dotted-quad parser.
// No dependencies; used by ipv4p_step and the top level.
package ipv4p_pkg;

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_DOT  = 8'h2E;
   localparam logic [9:0] OCTET_MAX = 10'd255;
   localparam logic [1:0] MAX_DIGITS = 2'd3;
   localparam logic [1:0] LAST_OCTET = 2'd3;

   typedef struct packed {
      logic        rejected;
      logic        inside_octet;
      logic [1:0]  octet_number;
      logic [1:0]  digit_count;
      logic [9:0]  octet_accum;
      logic [23:0] upper_octets;
   } parse_state_type;

   typedef struct packed {
      logic        is_valid;
      logic [31:0] address;
   } result_type;

endpackage

// ===== hdl/ipv4p_step.sv =====
// Per-character next-state logic and end-of-string result for the parser.
// Depends on ipv4p_pkg for the state and result types and character codes.
module ipv4p_step (
   input  ipv4p_pkg::parse_state_type state_cur,
   input  logic [7:0]                 char_code,
   input  logic                       last_char,
   output ipv4p_pkg::parse_state_type state_nxt,
   output ipv4p_pkg::result_type      result
);

   ipv4p_pkg::parse_state_type taken;
   logic [9:0] times_ten;
   logic [9:0] digit_val;
   logic       ok;

   assign times_ten = {state_cur.octet_accum[6:0], 3'b000}
                    + {state_cur.octet_accum[8:0], 1'b0};
   assign digit_val = {2'b00, char_code - ipv4p_pkg::CH_ZERO};

   always_comb begin
      taken = state_cur;
      if (!state_cur.rejected) begin
         if (char_code inside {[ipv4p_pkg::CH_ZERO : ipv4p_pkg::CH_NINE]}) begin
            if (state_cur.digit_count >= ipv4p_pkg::MAX_DIGITS) begin
               taken.rejected = 1'b1;
            end else begin
               taken.octet_accum  = times_ten + digit_val;
               taken.digit_count  = state_cur.digit_count + 2'd1;
               taken.inside_octet = 1'b1;
            end
         end else if (char_code == ipv4p_pkg::CH_DOT) begin
            if (!state_cur.inside_octet || state_cur.octet_number >= ipv4p_pkg::LAST_OCTET
                || state_cur.octet_accum > ipv4p_pkg::OCTET_MAX) begin
               taken.rejected = 1'b1;
            end else begin
               taken.upper_octets = {state_cur.upper_octets[15:0],
                                     state_cur.octet_accum[7:0]};
               taken.octet_number = state_cur.octet_number + 2'd1;
               taken.inside_octet = 1'b0;
               taken.digit_count  = 2'd0;
               taken.octet_accum  = 10'd0;
            end
         end else begin
            taken.rejected = 1'b1;
         end
      end
   end

   assign ok = !taken.rejected && taken.inside_octet
             && (taken.octet_number == ipv4p_pkg::LAST_OCTET)
             && (taken.octet_accum <= ipv4p_pkg::OCTET_MAX);

   assign result.is_valid = ok;
   assign result.address  = ok ? {taken.upper_octets, taken.octet_accum[7:0]} : 32'd0;

   // The final character of a string returns the parser to its start state.
   assign state_nxt = last_char ? '0 : taken;

endmodule

// ===== hdl/strict_ipv4_dotted_quad_parser_unit.sv =====
// Top level of the strict IPv4 dotted-quad parser: input register, parse state,
// result register. Depends on ipv4p_pkg, ipv4p_step and the assertion macro header.
//
// Usage: a string is fed one character per item on the req_ channel
// (req_char_code, with req_last_char set on its final character). Only the final
// character produces an item on the rsp_ channel: rsp_is_valid says whether the
// whole string was exactly four decimal octets of value 0 to 255 joined by dots,
// and rsp_address holds the address with the first octet in bits 31..24, or zero.
// Throughput is one character per cycle, set by the single registered pass of
// the per-character step logic, except when a final character must wait for the
// result slot. The final character is held in the input register; its result is
// loaded into the result register, which drives rsp_valid, once the slot is free.
// While the result register holds an item the receiver has not taken, ordinary
// characters keep flowing; only a further final character waits in the input
// register, and req_ready drops until the result slot frees.
// A synchronous active-high reset empties both registers and clears the parse
// state, so the next character starts a fresh string.
`include "strict_ipv4_dotted_quad_parser_unit_defines.svh"

module strict_ipv4_dotted_quad_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_valid,
   output logic [31:0] rsp_address
);

   logic                       in_valid_ff;
   logic                       in_valid_in;
   logic [7:0]                 char_ff;
   logic                       last_ff;
   ipv4p_pkg::parse_state_type state_ff;
   ipv4p_pkg::parse_state_type state_in;
   ipv4p_pkg::result_type      result_ff;
   ipv4p_pkg::result_type      step_result;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       slot_free;
   logic                       proc_fire;
   logic                       req_fire;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign proc_fire = in_valid_ff && (!last_ff || slot_free);
   assign req_ready = !in_valid_ff || proc_fire;
   assign req_fire  = req_valid && req_ready;

   ipv4p_step u_step (
      .state_cur (state_ff),
      .char_code (char_ff),
      .last_char (last_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   assign in_valid_in  = req_fire || (in_valid_ff && !proc_fire);
   assign rsp_valid_in = (proc_fire && last_ff) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (proc_fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         char_ff <= req_char_code;
         last_ff <= req_last_char;
      end
      if (proc_fire && last_ff) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_valid = result_ff.is_valid;
   assign rsp_address  = result_ff.address;

   `IPV4P_ASSERT_NOW(a_invalid_zero_address, rsp_valid_ff && !result_ff.is_valid, result_ff.address == 32'd0, "invalid result carries a non-zero address")
   `IPV4P_ASSERT_NEXT(a_clear_after_last, proc_fire && last_ff, state_ff == '0, "parse state not cleared after the final character")
   `IPV4P_ASSERT_NOW(a_stall_only_on_last, in_valid_ff && !req_ready, last_ff && rsp_valid_ff && !rsp_ready, "input stalled without a blocked final character")

endmodule
